// File: hdl/msps_pkg.sv
`default_nettype none

package msps_pkg;

   localparam int OP_W    = 2;
   localparam int CHAN_W  = 3;
   localparam int RAW_W   = 10;
   localparam int LINE_W  = 7;
   localparam int WIDTH_W = 12;
   localparam int GAP_W   = 16;

   localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
   localparam logic [OP_W-1:0] OP_ADC    = 2'd1;
   localparam logic [OP_W-1:0] OP_SERIAL = 2'd2;

   localparam logic [WIDTH_W-1:0] WIDTH_RESET = 12'd1500;
   localparam logic [GAP_W-1:0]   GAP_RESET   = 16'd10000;

   // floor(code * 176 / 100) is computed as (code * ADC_MUL) >> ADC_SHIFT,
   // with ADC_MUL = 176 * ceil(2^24 / 100); exact for every 10-bit code.
   localparam int ADC_MUL_W = 25;
   localparam int ADC_PROD_W = RAW_W + ADC_MUL_W;
   localparam logic [ADC_MUL_W-1:0] ADC_MUL    = 25'd29528048;
   localparam int                   ADC_SHIFT  = 24;
   localparam logic [WIDTH_W-1:0]   ADC_OFFSET = 12'd600;

   localparam logic [WIDTH_W-1:0] SERIAL_CENTER = 12'd1500;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [CHAN_W-1:0] channel;
      logic [RAW_W-1:0]  raw_value;
   } req_word_type;

   typedef struct packed {
      logic              tick;
      logic              load;
      logic [CHAN_W-1:0] channel;
      logic [WIDTH_W-1:0] width;
   } seq_cmd_type;

endpackage

`default_nettype wire

// File: hdl/msps_if.sv
`default_nettype none

interface msps_req_if
   import msps_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [CHAN_W-1:0] channel;
   logic [RAW_W-1:0]  raw_value;

   modport source (output valid, output op, output channel, output raw_value, input ready);
   modport sink   (input valid, input op, input channel, input raw_value, output ready);
endinterface

interface msps_rsp_if
   import msps_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [LINE_W-1:0]  servo_lines;
   logic [WIDTH_W-1:0] loaded_width;

   modport source (output valid, output servo_lines, output loaded_width, input ready);
   modport sink   (input valid, input servo_lines, input loaded_width, output ready);
endinterface

`default_nettype wire

// File: hdl/multi_servo_pulse_sequencer.sv
`default_nettype none

// Channel    Dir   Contents
// req_chan   in    op, channel, raw_value (tick or width load)
// rsp_chan   out   servo_lines, loaded_width (one word per request word)
// csr_*      in    low_gap_ticks write, no read-back
//
// One request word is taken every cycle while req_chan.ready is high; its response
// passes through an input register and a result register.
// The frame state is updated in the cycle the word leaves the input register.
// Reset sets all widths to 1500 ticks, the gap to 10000 and starts channel 0.
// A stalled response holds the input register, which then holds req_chan.ready low.

module multi_servo_pulse_sequencer
   import msps_pkg::*;
#(
   parameter int NUM_CHANNELS = 7
)(
   input  wire logic              clock,
   input  wire logic              reset,
   msps_req_if.sink               req_chan,
   msps_rsp_if.source             rsp_chan,
   input  wire logic              csr_wr_en,
   input  wire logic [GAP_W-1:0]  csr_wr_data
);

   logic               in_valid_ff;
   logic               in_valid_in;
   req_word_type       in_word_ff;
   logic               out_valid_ff;
   logic               out_valid_in;
   logic [LINE_W-1:0]  lines_ff;
   logic [WIDTH_W-1:0] width_ff;
   logic [GAP_W-1:0]   gap_ff;
   logic               advance;
   logic               take_req;
   logic [WIDTH_W-1:0] map_width;
   logic [LINE_W-1:0]  cur_lines;
   seq_cmd_type        cmd;

   msps_width_map u_width_map (
      .op        (in_word_ff.op),
      .raw_value (in_word_ff.raw_value),
      .width     (map_width)
   );

   always_comb begin
      advance  = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
      take_req = req_chan.valid && req_chan.ready;

      cmd.tick    = (in_word_ff.op == OP_TICK);
      cmd.load    = (in_word_ff.op == OP_ADC) || (in_word_ff.op == OP_SERIAL);
      cmd.channel = in_word_ff.channel;
      cmd.width   = map_width;

      in_valid_in  = take_req || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && !rsp_chan.ready);
   end

   assign req_chan.ready        = !in_valid_ff || advance;
   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.servo_lines  = lines_ff;
   assign rsp_chan.loaded_width = width_ff;

   msps_frame_timer #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_frame_timer (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (advance),
      .cmd       (cmd),
      .gap_ticks (gap_ff),
      .lines     (cur_lines)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         gap_ff       <= GAP_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            gap_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         in_word_ff.op        <= req_chan.op;
         in_word_ff.channel   <= req_chan.channel;
         in_word_ff.raw_value <= req_chan.raw_value;
      end
      if (advance) begin
         lines_ff <= cur_lines;
         width_ff <= map_width;
      end
   end

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !in_valid_ff && !out_valid_ff)
      else $error("Pipeline not empty after reset.");

   a_one_line: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> $onehot0(lines_ff))
      else $error("More than one servo line high.");

   a_input_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff && $stable(in_word_ff))
      else $error("Input register lost a waiting word.");

   a_tick_no_width: assert property (@(posedge clock) disable iff (reset)
      (advance && cmd.tick) |=> (width_ff == '0))
      else $error("Tick word reported a loaded width.");

endmodule

`default_nettype wire

// File: hdl/msps_width_map.sv
`default_nettype none

module msps_width_map
   import msps_pkg::*;
(
   input  wire logic [OP_W-1:0]    op,
   input  wire logic [RAW_W-1:0]   raw_value,
   output      logic [WIDTH_W-1:0] width
);

   logic [ADC_PROD_W-1:0] adc_prod;
   logic [WIDTH_W-1:0]    adc_width;
   logic [7:0]            ser_byte;
   logic [WIDTH_W-1:0]    ser_scaled;
   logic [WIDTH_W-1:0]    ser_width;

   always_comb begin
      adc_prod  = ADC_PROD_W'(raw_value) * ADC_PROD_W'(ADC_MUL);
      adc_width = WIDTH_W'(adc_prod >> ADC_SHIFT) + ADC_OFFSET;

      // The serial byte is scaled by 15, then the offset from the center is
      // halved with truncation toward zero on either side.
      ser_byte   = raw_value[7:0];
      ser_scaled = (WIDTH_W'(ser_byte) << 4) - WIDTH_W'(ser_byte);
      if (ser_scaled >= SERIAL_CENTER) begin
         ser_width = ((ser_scaled - SERIAL_CENTER) >> 1) + SERIAL_CENTER;
      end else begin
         ser_width = SERIAL_CENTER - ((SERIAL_CENTER - ser_scaled) >> 1);
      end

      unique case (op)
         OP_ADC: begin
            width = adc_width;
         end
         OP_SERIAL: begin
            width = ser_width;
         end
         default: begin
            width = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: hdl/msps_frame_timer.sv
`default_nettype none

module msps_frame_timer
   import msps_pkg::*;
#(
   parameter int NUM_CHANNELS = 7
)(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               cmd_valid,
   input  wire seq_cmd_type        cmd,
   input  wire logic [GAP_W-1:0]   gap_ticks,
   output      logic [LINE_W-1:0]  lines
);

   localparam int SLOT_W = $clog2(NUM_CHANNELS + 1);
   localparam int IDX_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   logic [WIDTH_W-1:0] widths_ff [NUM_CHANNELS];
   logic [SLOT_W-1:0]  slot_ff;
   logic [SLOT_W-1:0]  slot_in;
   logic [GAP_W-1:0]   ticks_ff;
   logic [GAP_W-1:0]   ticks_in;
   logic [SLOT_W-1:0]  next_slot;
   logic [GAP_W-1:0]   next_len;
   logic               store_hit;

   always_comb begin
      next_slot = (slot_ff == SLOT_W'(NUM_CHANNELS)) ? '0 : slot_ff + SLOT_W'(1);
      if (next_slot < SLOT_W'(NUM_CHANNELS)) begin
         next_len = GAP_W'(widths_ff[IDX_W'(next_slot)]);
      end else begin
         next_len = gap_ticks;
      end

      slot_in  = slot_ff;
      ticks_in = ticks_ff;
      if (cmd_valid && cmd.tick) begin
         if (ticks_ff <= GAP_W'(1)) begin
            slot_in  = next_slot;
            ticks_in = next_len;
         end else begin
            ticks_in = ticks_ff - GAP_W'(1);
         end
      end

      store_hit = cmd_valid && cmd.load && (int'(cmd.channel) < NUM_CHANNELS);

      for (int k = 0; k < LINE_W; k++) begin
         lines[k] = (k < NUM_CHANNELS) && (slot_ff == SLOT_W'(k));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff  <= '0;
         ticks_ff <= GAP_W'(WIDTH_RESET);
         for (int k = 0; k < NUM_CHANNELS; k++) begin
            widths_ff[k] <= WIDTH_RESET;
         end
      end else begin
         slot_ff  <= slot_in;
         ticks_ff <= ticks_in;
         if (store_hit) begin
            widths_ff[IDX_W'(cmd.channel)] <= cmd.width;
         end
      end
   end

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= SLOT_W'(NUM_CHANNELS))
      else $error("Active slot beyond the gap slot.");

   a_hold_without_tick: assert property (@(posedge clock) disable iff (reset)
      !(cmd_valid && cmd.tick) |=> $stable(slot_ff) && $stable(ticks_ff))
      else $error("Frame timer moved without a tick.");

   a_countdown: assert property (@(posedge clock) disable iff (reset)
      (cmd_valid && cmd.tick && ticks_ff > GAP_W'(1)) |=>
         (ticks_ff == $past(ticks_ff) - GAP_W'(1)) && $stable(slot_ff))
      else $error("Tick count did not step down by one.");

endmodule

`default_nettype wire

// File: tb/tb_multi_servo_pulse_sequencer.sv
`timescale 1ns / 1ps

module tb_multi_servo_pulse_sequencer;
   import msps_pkg::*;

   localparam int SERVO_COUNT = 7;
   localparam int DRAIN_CYCLES = 8;
   localparam int STALL_LIMIT = 5000;
   localparam int PHASE_LOADS = 10;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [LINE_W-1:0]  servo_lines;
      logic [WIDTH_W-1:0] loaded_width;
   } servo_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en;
   logic [GAP_W-1:0] csr_wr_data;

   msps_req_if req_bus ();
   msps_rsp_if rsp_bus ();

   multi_servo_pulse_sequencer #(
      .NUM_CHANNELS(SERVO_COUNT)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #5 clock = ~clock;

   req_word_type   pending_words[$];
   servo_word_type servo_words_due[$];
   req_word_type   word_on_bus;

   logic [WIDTH_W-1:0] width_table [SERVO_COUNT];
   int                 frame_slot;
   logic [GAP_W-1:0]   slot_ticks;
   logic [GAP_W-1:0]   gap_ticks;

   int mismatch_count = 0;
   int idle_cycles = 0;
   int send_pause = 0;
   int send_stretch = 0;
   bit send_calm = 1'b0;
   int recv_pause = 0;
   int recv_stretch = 0;
   bit recv_calm = 1'b0;

   // Advances the frame by one word and returns the levels seen during it.
   function automatic servo_word_type step_servo_frame(req_word_type w);
      servo_word_type r;
      int b;
      int v;
      r.servo_lines = (frame_slot < SERVO_COUNT) ? LINE_W'(1 << frame_slot) : '0;
      r.loaded_width = '0;
      case (w.op)
         OP_TICK: begin
            if (slot_ticks <= 1) begin
               frame_slot = (frame_slot >= SERVO_COUNT) ? 0 : frame_slot + 1;
               slot_ticks = (frame_slot < SERVO_COUNT) ? GAP_W'(width_table[frame_slot])
                                                       : gap_ticks;
            end else begin
               slot_ticks = slot_ticks - 1'b1;
            end
         end
         OP_ADC, OP_SERIAL: begin
            if (w.op == OP_ADC) begin
               v = int'(w.raw_value) * 176 / 100 + 600;
            end else begin
               b = int'(w.raw_value[7:0]);
               v = (b - 100) * 15 / 2 + 1500;
               if (v < 0) v = 0;
               if (v > 4095) v = 4095;
            end
            r.loaded_width = WIDTH_W'(v);
            if (int'(w.channel) < SERVO_COUNT) width_table[w.channel] = r.loaded_width;
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   function automatic int pick_pause(bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic queue_word(logic [OP_W-1:0] op, int chan, int raw);
      req_word_type w;
      w.op = op;
      w.channel = CHAN_W'(chan);
      w.raw_value = RAW_W'(raw);
      pending_words.push_back(w);
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_words.size() != 0 || req_bus.valid || servo_words_due.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_gap(logic [GAP_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      gap_ticks = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   always @(posedge clock) begin : req_driver
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            servo_words_due.push_back(step_servo_frame(word_on_bus));
         end
         if (send_stretch == 0) begin
            send_calm = ($urandom_range(0, 2) == 0);
            send_stretch = $urandom_range(30, 300);
         end else begin
            send_stretch--;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (send_pause > 0) begin
               send_pause--;
               req_bus.valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
               word_on_bus = pending_words.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.op <= word_on_bus.op;
               req_bus.channel <= word_on_bus.channel;
               req_bus.raw_value <= word_on_bus.raw_value;
               send_pause = pick_pause(send_calm);
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      servo_word_type due;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (servo_words_due.size() == 0) begin
               $display("%0t: word with nothing outstanding, servo_lines %h loaded_width %h",
                        $time, rsp_bus.servo_lines, rsp_bus.loaded_width);
               mismatch_count++;
            end else begin
               due = servo_words_due.pop_front();
               if (rsp_bus.servo_lines !== due.servo_lines) begin
                  $display("%0t: servo_lines expected %h, got %h",
                           $time, due.servo_lines, rsp_bus.servo_lines);
                  mismatch_count++;
               end
               if (rsp_bus.loaded_width !== due.loaded_width) begin
                  $display("%0t: loaded_width expected %0d, got %0d",
                           $time, due.loaded_width, rsp_bus.loaded_width);
                  mismatch_count++;
               end
            end
         end
         if (recv_stretch == 0) begin
            recv_calm = ($urandom_range(0, 2) == 0);
            recv_stretch = $urandom_range(30, 300);
         end else begin
            recv_stretch--;
         end
         if (recv_pause > 0) begin
            recv_pause--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            if ($urandom_range(0, 99) < 25) recv_pause = pick_pause(recv_calm);
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [GAP_W-1:0] gap_plan [4];
      int r;
      int run;
      req_bus.valid = 1'b0;
      req_bus.op = OP_TICK;
      req_bus.channel = '0;
      req_bus.raw_value = '0;
      rsp_bus.ready = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      for (int k = 0; k < SERVO_COUNT; k++) width_table[k] = WIDTH_RESET;
      frame_slot = 0;
      slot_ticks = GAP_W'(WIDTH_RESET);
      gap_ticks = GAP_RESET;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Extremes of both width maps, serial bytes with upper code bits set,
      // loads aimed past the last channel, and the unused operation.
      queue_word(OP_ADC, 0, 0);
      queue_word(OP_ADC, 1, 1023);
      queue_word(OP_SERIAL, 2, 0);
      queue_word(OP_SERIAL, 3, 255);
      queue_word(OP_SERIAL, 4, 100);
      queue_word(OP_SERIAL, 5, 1023);
      queue_word(OP_SERIAL, 6, 'h2AA);
      queue_word(OP_TICK, 7, 1023);
      queue_word(OP_ADC, 7, 512);
      queue_word(OP_SERIAL, 7, 300);
      queue_word(OP_UNUSED, 5, 1023);
      queue_word(OP_UNUSED, 7, 0);
      queue_word(OP_TICK, 0, 0);
      queue_word(OP_ADC, 2, 'h155);
      queue_word(OP_ADC, 3, 'h2AA);
      queue_word(OP_SERIAL, 1, 99);
      queue_word(OP_SERIAL, 0, 101);
      queue_word(OP_TICK, 5, 'h155);
      wait_idle();

      gap_plan[0] = '0;
      gap_plan[1] = 16'd1;
      gap_plan[2] = GAP_W'($urandom_range(2, 400));
      gap_plan[3] = '1;
      for (int phase = 0; phase < 4; phase++) begin
         write_gap(gap_plan[phase]);
         for (int n = 0; n < PHASE_LOADS; n++) begin
            r = $urandom_range(0, 99);
            if (r < 46) begin
               queue_word(OP_ADC, $urandom_range(0, 7),
                          ($urandom_range(0, 9) < 7) ? $urandom_range(0, 24)
                                                     : $urandom_range(0, 1023));
            end else if (r < 92) begin
               queue_word(OP_SERIAL, $urandom_range(0, 7),
                          ($urandom_range(0, 9) < 6) ? $urandom_range(0, 12)
                                                     : $urandom_range(0, 1023));
            end else begin
               queue_word(OP_UNUSED, $urandom_range(0, 7), $urandom_range(0, 1023));
            end
            run = $urandom_range(0, 36);
            repeat (run) queue_word(OP_TICK, $urandom_range(0, 7), $urandom_range(0, 1023));
         end
         wait_idle();
      end

      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
